// ===== src/taq_pkg.sv =====
// Package: shared types and constants for the tree ancestor query engine
package taq_pkg;

    localparam int unsigned ACT_W     = 2;
    localparam int unsigned IN_NODE_W = 10;
    localparam int unsigned IN_COST_W = 16;
    localparam int unsigned STEPS_W   = 10;
    localparam int unsigned LEVEL_W   = 11;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 11'd2047;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_KTH   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // datapath commands from the controller
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,       // latch request, clamp nodes
        CMD_RD_LVL,     // read levels of u and v
        CMD_ORDER,      // swap so u is deeper
        CMD_ADD_LVL,    // write new node level, row 0
        CMD_RD_ROW,     // read anc/cost of (u, i) and (v, i)
        CMD_RD_MID,     // read row i of mid, the ancestor just fetched
        CMD_ADD_STEP,   // write row i+1 of new node
        CMD_RD_ALVL,    // read level of ancestor a
        CMD_UP_STEP,    // conditional lift of u
        CMD_BOTH_STEP,  // joint lift of u and v
        CMD_FINISH_Q,   // final row 0 fold
        CMD_KTH_STEP,   // kth ancestor step
        CMD_DONE_ZERO   // result 0/0
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic [4:0] lvl;
    } t_ctrl;

    typedef struct packed {
        logic u_eq_v;
        logic kth_over;
    } t_stat;

endpackage

// ===== src/taq_if.sv =====
// Interface: valid/ready channel carrying a packed payload
interface taq_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/taq_ram.sv =====
// Generic single-port RAM with registered read
module taq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/taq_datapath.sv =====
// Datapath: table memories, node registers and running maximum
module taq_datapath #(
    parameter int unsigned NODES     = 1024,
    parameter int unsigned LEVELS    = 10,
    parameter int unsigned COST_BITS = 16
) (
    input  logic                          i_clk,
    input  taq_pkg::t_ctrl                i_ctrl,
    input  logic [taq_pkg::ACT_W-1:0]     i_act,
    input  logic [taq_pkg::IN_NODE_W-1:0] i_a,
    input  logic [taq_pkg::IN_NODE_W-1:0] i_b,
    input  logic [taq_pkg::IN_COST_W-1:0] i_cost,
    input  logic [taq_pkg::STEPS_W-1:0]   i_steps,
    output taq_pkg::t_stat                o_stat,
    output logic [taq_pkg::IN_NODE_W-1:0] o_node,
    output logic [taq_pkg::IN_COST_W-1:0] o_pmax
);
    localparam int unsigned NW  = $clog2(NODES);
    localparam int unsigned LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int unsigned TD  = NODES * LEVELS;
    localparam int unsigned TW  = $clog2(TD);
    localparam int unsigned LVW = taq_pkg::LEVEL_W;

    // second copies of the row tables give two reads per cycle (both ports written)
    logic [NW-1:0]        r_u, r_v, n_u, n_v;
    logic [COST_BITS-1:0] r_res, n_res;
    logic [LVW-1:0]       r_lv, n_lv;
    logic [taq_pkg::STEPS_W-1:0] r_k, n_k;

    logic [NW-1:0]        anc0_q, anc1_q;
    logic [COST_BITS-1:0] cst0_q, cst1_q;
    logic [LVW-1:0]       lvl0_q, lvl1_q;

    logic [TW-1:0]        addr0, addr1;
    logic                 we_t;
    logic [NW-1:0]        w_anc;
    logic [COST_BITS-1:0] w_cst;
    logic [NW-1:0]        lad0, lad1;
    logic                 we_l;
    logic [LVW-1:0]       w_lvl;
    logic [LW-1:0]        idx;

    function automatic logic [NW-1:0] clampn(input logic [taq_pkg::IN_NODE_W-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return (w < NODES) ? NW'(w) : '0;
    endfunction

    function automatic logic [TW-1:0] cel(input logic [NW-1:0] n, input logic [LW-1:0] i);
        return TW'(32'(n) * LEVELS + 32'(i));
    endfunction

    assign idx = LW'(i_ctrl.lvl);

    // node 0 reads as zero everywhere; its rows are never written
    logic [NW-1:0] anc0, anc1;
    logic [COST_BITS-1:0] cst0, cst1;
    logic [LVW-1:0] lvl0, lvl1;
    logic r_z0, r_z1, r_zl0, r_zl1;
    assign anc0 = r_z0 ? '0 : anc0_q;
    assign anc1 = r_z1 ? '0 : anc1_q;
    assign cst0 = r_z0 ? '0 : cst0_q;
    assign cst1 = r_z1 ? '0 : cst1_q;
    assign lvl0 = r_zl0 ? '0 : lvl0_q;
    assign lvl1 = r_zl1 ? '0 : lvl1_q;

    logic [COST_BITS-1:0] satc;
    always_comb begin
        logic [31:0] c32;
        c32 = 32'(i_cost);
        satc = (c32 > (32'hFFFF_FFFF >> (32 - COST_BITS))) ? '1 : COST_BITS'(c32);
    end

    always_comb begin
        n_u = r_u; n_v = r_v; n_res = r_res; n_lv = r_lv;
        n_k = r_k;
        addr0 = cel(r_u, idx); addr1 = cel(r_v, idx);
        lad0 = r_u; lad1 = r_v;
        we_t = 1'b0; w_anc = anc0; w_cst = cst0;
        we_l = 1'b0; w_lvl = '0;
        unique case (i_ctrl.cmd)
            taq_pkg::CMD_LOAD: begin
                n_u = clampn(i_a); n_v = clampn(i_b);
                n_res = '0; n_k = i_steps;
                if (i_act == taq_pkg::ACT_ADD) n_res = satc;
            end
            taq_pkg::CMD_RD_LVL: begin
                lad0 = r_u; lad1 = r_v;
            end
            taq_pkg::CMD_ORDER: begin
                n_lv = lvl1;
                if (lvl0 < lvl1) begin
                    n_u = r_v; n_v = r_u; n_lv = lvl0;
                end
            end
            taq_pkg::CMD_ADD_LVL: begin
                // u new node, v parent; lvl1 holds parent level
                we_l = 1'b1; lad0 = r_u; lad1 = r_u;
                w_lvl = (lvl1 == taq_pkg::LEVEL_MAX) ? taq_pkg::LEVEL_MAX : lvl1 + 1'b1;
                we_t = 1'b1; addr0 = cel(r_u, '0); addr1 = addr0;
                w_anc = r_v; w_cst = r_res;
            end
            taq_pkg::CMD_RD_ROW: begin
                addr0 = cel(r_u, idx); addr1 = cel(r_v, idx);
            end
            taq_pkg::CMD_RD_MID: begin
                // anc0 holds mid, row i of u is read again on port 0
                addr1 = cel(anc0, idx);
            end
            taq_pkg::CMD_ADD_STEP: begin
                // anc0/cst0 = row i of u, anc1/cst1 = row i of mid
                we_t = 1'b1; addr0 = cel(r_u, LW'(idx + 1'b1)); addr1 = addr0;
                w_anc = anc1; w_cst = (cst0 > cst1) ? cst0 : cst1;
            end
            taq_pkg::CMD_RD_ALVL: begin
                lad0 = anc0; n_v = r_v;
            end
            taq_pkg::CMD_UP_STEP: begin
                if (lvl0 >= r_lv) begin
                    n_res = (r_res > cst0) ? r_res : cst0;
                    n_u = anc0;
                end
            end
            taq_pkg::CMD_BOTH_STEP: begin
                if (anc0 != anc1) begin
                    n_res = (r_res > cst0) ? r_res : cst0;
                    n_res = (n_res > cst1) ? n_res : cst1;
                    n_u = anc0; n_v = anc1;
                end
            end
            taq_pkg::CMD_FINISH_Q: begin
                n_res = (r_res > cst0) ? r_res : cst0;
                n_res = (n_res > cst1) ? n_res : cst1;
                n_u = anc0;
            end
            taq_pkg::CMD_KTH_STEP: begin
                if (r_k[0]) n_u = anc0;
                n_k = r_k >> 1;
            end
            taq_pkg::CMD_DONE_ZERO: begin
                n_u = '0; n_res = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u; r_v <= n_v; r_res <= n_res; r_lv <= n_lv;
        r_k <= n_k;
        r_z0 <= (addr0 < TW'(LEVELS)); r_z1 <= (addr1 < TW'(LEVELS));
        r_zl0 <= (lad0 == '0); r_zl1 <= (lad1 == '0);
    end

    taq_ram #(.WIDTH(NW), .DEPTH(TD)) u_anc0 (
        .i_clk(i_clk), .i_we(we_t), .i_addr(addr0), .i_wdata(w_anc), .o_rdata(anc0_q));
    taq_ram #(.WIDTH(NW), .DEPTH(TD)) u_anc1 (
        .i_clk(i_clk), .i_we(we_t), .i_addr(addr1), .i_wdata(w_anc), .o_rdata(anc1_q));
    taq_ram #(.WIDTH(COST_BITS), .DEPTH(TD)) u_cst0 (
        .i_clk(i_clk), .i_we(we_t), .i_addr(addr0), .i_wdata(w_cst), .o_rdata(cst0_q));
    taq_ram #(.WIDTH(COST_BITS), .DEPTH(TD)) u_cst1 (
        .i_clk(i_clk), .i_we(we_t), .i_addr(addr1), .i_wdata(w_cst), .o_rdata(cst1_q));
    taq_ram #(.WIDTH(LVW), .DEPTH(NODES)) u_lvl0 (
        .i_clk(i_clk), .i_we(we_l), .i_addr(lad0), .i_wdata(w_lvl), .o_rdata(lvl0_q));
    taq_ram #(.WIDTH(LVW), .DEPTH(NODES)) u_lvl1 (
        .i_clk(i_clk), .i_we(we_l), .i_addr(lad1), .i_wdata(w_lvl), .o_rdata(lvl1_q));

    assign o_stat.u_eq_v   = (r_u == r_v);
    assign o_stat.kth_over = (r_k != '0);
    assign o_node = taq_pkg::IN_NODE_W'(r_u);
    assign o_pmax = taq_pkg::IN_COST_W'(r_res);
endmodule

// ===== src/taq_ctrl.sv =====
// Controller: sequences add, query and kth-ancestor over table rows
module taq_ctrl #(
    parameter int unsigned LEVELS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [taq_pkg::ACT_W-1:0] i_act,
    input  logic                      i_node_a_zero,
    input  taq_pkg::t_stat            i_stat,
    input  logic                      i_out_taken,
    output taq_pkg::t_ctrl            o_ctrl,
    output logic                      o_busy,
    output logic                      o_res_valid,
    output logic                      o_zero_res
);
    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RLVL, S_ORDER, S_ADDL, S_RROW, S_AROW, S_ASTEP,
        S_QROW, S_QALVL, S_QUP, S_QBROW, S_QBOTH, S_QFRD, S_QFIN, S_KROW, S_KSTEP
    } t_state;

    t_state r_st, n_st;
    logic [4:0] r_i, n_i;
    taq_pkg::t_action r_act, n_act;
    logic r_skip, n_skip;
    logic r_out, n_out;
    logic r_zero, n_zero;
    taq_pkg::t_cmd cmd;

    always_comb begin
        n_st = r_st; n_i = r_i; n_act = r_act; n_skip = r_skip;
        n_out = r_out && !i_out_taken; n_zero = r_zero;
        cmd = taq_pkg::CMD_IDLE;
        unique case (r_st)
            S_IDLE: if (i_start) begin
                n_act = taq_pkg::t_action'(i_act); n_skip = i_node_a_zero;
                cmd = taq_pkg::CMD_LOAD; n_st = S_LOAD;
            end
            S_LOAD: begin
                cmd = taq_pkg::CMD_RD_LVL;
                unique case (r_act)
                    taq_pkg::ACT_ADD: n_st = r_skip ? S_IDLE : S_RLVL;
                    taq_pkg::ACT_QUERY: n_st = S_ORDER;
                    taq_pkg::ACT_KTH: begin n_i = '0; n_st = S_KROW; end
                    default: n_st = S_IDLE;
                endcase
                if ((r_act == taq_pkg::ACT_ADD && r_skip) || r_act == taq_pkg::ACT_NONE) begin
                    n_out = 1'b1; n_zero = 1'b1;
                end
            end
            S_RLVL: begin
                cmd = taq_pkg::CMD_ADD_LVL; n_i = '0;
                n_st = (LEVELS > 1) ? S_RROW : S_IDLE;
                if (LEVELS == 1) begin n_out = 1'b1; n_zero = 1'b1; end
            end
            S_RROW: begin cmd = taq_pkg::CMD_RD_ROW; n_st = S_AROW; end
            S_AROW: begin cmd = taq_pkg::CMD_RD_MID; n_st = S_ASTEP; end
            S_ASTEP: begin
                cmd = taq_pkg::CMD_ADD_STEP;
                if (32'(r_i) + 2 >= LEVELS) begin
                    n_st = S_IDLE; n_out = 1'b1; n_zero = 1'b1;
                end else begin
                    n_i = r_i + 1'b1; n_st = S_RROW;
                end
            end
            S_ORDER: begin cmd = taq_pkg::CMD_ORDER; n_i = 5'(LEVELS - 1); n_st = S_QROW; end
            S_QROW: begin cmd = taq_pkg::CMD_RD_ROW; n_st = S_QALVL; end
            S_QALVL: begin cmd = taq_pkg::CMD_RD_ALVL; n_st = S_QUP; end
            S_QUP: begin
                cmd = taq_pkg::CMD_UP_STEP;
                if (r_i == '0) begin n_i = 5'(LEVELS - 1); n_st = S_QBROW; end
                else begin n_i = r_i - 1'b1; n_st = S_QROW; end
            end
            S_QBROW: begin
                cmd = taq_pkg::CMD_RD_ROW;
                if (i_stat.u_eq_v) begin n_st = S_IDLE; n_out = 1'b1; n_zero = 1'b0; end
                else n_st = S_QBOTH;
            end
            S_QBOTH: begin
                cmd = taq_pkg::CMD_BOTH_STEP;
                if (r_i == '0) n_st = S_QFRD;
                else begin n_i = r_i - 1'b1; n_st = S_QBROW; end
            end
            // the last joint lift may have moved u and v: read row 0 again
            S_QFRD: begin cmd = taq_pkg::CMD_RD_ROW; n_st = S_QFIN; end
            S_QFIN: begin
                cmd = taq_pkg::CMD_FINISH_Q; n_st = S_IDLE; n_out = 1'b1; n_zero = 1'b0;
            end
            S_KROW: begin
                cmd = taq_pkg::CMD_RD_ROW;
                if (!i_stat.kth_over) begin n_st = S_IDLE; n_out = 1'b1; n_zero = 1'b0; end
                else if (32'(r_i) >= LEVELS) begin
                    cmd = taq_pkg::CMD_DONE_ZERO; n_st = S_IDLE; n_out = 1'b1; n_zero = 1'b0;
                end else n_st = S_KSTEP;
            end
            S_KSTEP: begin cmd = taq_pkg::CMD_KTH_STEP; n_i = r_i + 1'b1; n_st = S_KROW; end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_i <= '0; r_act <= taq_pkg::ACT_NONE;
            r_skip <= 1'b0; r_out <= 1'b0; r_zero <= 1'b0;
        end else begin
            r_st <= n_st; r_i <= n_i; r_act <= n_act;
            r_skip <= n_skip; r_out <= n_out; r_zero <= n_zero;
        end
    end

    assign o_ctrl.cmd = cmd;
    assign o_ctrl.lvl = (r_st == S_QFIN) ? 5'd0 : r_i;
    assign o_busy = (r_st != S_IDLE) || r_out;
    assign o_res_valid = r_out;
    assign o_zero_res = r_zero;
endmodule

// ===== src/tree_ancestor_query_engine.sv =====
// Top level: binary-lifting ancestor engine, controller plus datapath
//
// Requests enter on the in channel: action, node_a, node_b, edge_cost, steps.
// Each request gives exactly one result on the out channel: node_out, path_max.
// Add stores a node's level and its 2^i ancestor and path-maximum rows.
// Query returns lowest common ancestor and path maximum; kth climbs steps levels.
// One request is in flight at a time; in.ready is low from acceptance until
// the result has been taken, and the next request can be taken in the cycle after.
// Every step is one read of the row memories with registered data.
// Reset (synchronous, active low) clears the controller only and holds
// in.ready low; node 0 reads as zero through address decoding, other entries
// are undefined until added.
// When the receiver stalls the result is held in registers and no new
// request is taken until it leaves.
module tree_ancestor_query_engine #(
    parameter int unsigned NODES     = 1024,
    parameter int unsigned LEVELS    = 10,
    parameter int unsigned COST_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    taq_if.sink   in_req,
    taq_if.source out_res
);
    taq_pkg::t_ctrl ctrl;
    taq_pkg::t_stat stat;
    logic busy, rvalid, zres, start;
    logic [taq_pkg::IN_NODE_W-1:0] dp_node;
    logic [taq_pkg::IN_COST_W-1:0] dp_pmax;

    // payload: {action, node_a, node_b, edge_cost, steps}
    logic [1:0]  f_act;
    logic [9:0]  f_a, f_b, f_steps;
    logic [15:0] f_cost;
    assign {f_act, f_a, f_b, f_cost, f_steps} = in_req.data;

    assign in_req.ready = i_rst_n && !busy;
    assign start = in_req.valid && in_req.ready;

    taq_ctrl #(.LEVELS(LEVELS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_act(f_act),
        .i_node_a_zero(f_a == '0 || 32'(f_a) >= NODES), .i_stat(stat),
        .i_out_taken(out_res.ready), .o_ctrl(ctrl), .o_busy(busy),
        .o_res_valid(rvalid), .o_zero_res(zres));

    // request fields are latched by the datapath in the accepting cycle
    taq_datapath #(.NODES(NODES), .LEVELS(LEVELS), .COST_BITS(COST_BITS)) u_dp (
        .i_clk(i_clk), .i_ctrl(ctrl), .i_act(f_act), .i_a(f_a), .i_b(f_b),
        .i_cost(f_cost), .i_steps(f_steps), .o_stat(stat),
        .o_node(dp_node), .o_pmax(dp_pmax));

    assign out_res.valid = rvalid;
    assign out_res.data  = zres ? 26'd0 : {dp_node, dp_pmax};
endmodule
